FILE: sv/camera_view_mode_selector_assert.svh
// Assertion macros for the camera view mode selector.
// Expects clk and rst in the scope where the macros are used.
`ifndef CAMERA_VIEW_MODE_SELECTOR_ASSERT_SVH
`define CAMERA_VIEW_MODE_SELECTOR_ASSERT_SVH

// checked outside reset only
`define CVMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CVMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cvms_pkg.sv
// Shared types and codes for the camera view mode selector.
// No dependencies; used by cvms_regs, cvms_core and the top level.
package cvms_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_VIDEO_EN  = 3'd0;
  localparam logic [2:0] REG_LEFT_PREF = 3'd1;
  localparam logic [2:0] REG_SPD_ENTER = 3'd2;
  localparam logic [2:0] REG_SPD_EXIT  = 3'd3;
  localparam logic [2:0] REG_REL_DELAY = 3'd4;

  // item functions
  localparam logic [2:0] FUNC_SYNC      = 3'd0;
  localparam logic [2:0] FUNC_SET_REV   = 3'd1;
  localparam logic [2:0] FUNC_SET_LEFT  = 3'd2;
  localparam logic [2:0] FUNC_SET_RIGHT = 3'd3;
  localparam logic [2:0] FUNC_SPEED     = 3'd4;
  localparam logic [2:0] FUNC_TICK      = 3'd5;
  localparam logic [2:0] FUNC_OPEN      = 3'd6;
  localparam logic [2:0] FUNC_CLOSE     = 3'd7;

  // active view
  localparam logic [1:0] VIEW_NONE  = 2'd0;
  localparam logic [1:0] VIEW_REV   = 2'd1;
  localparam logic [1:0] VIEW_LEFT  = 2'd2;
  localparam logic [1:0] VIEW_RIGHT = 2'd3;

  // last turn
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // layout
  localparam logic [2:0] LAYOUT_SURROUND = 3'd0;
  localparam logic [2:0] LAYOUT_REV      = 3'd1;
  localparam logic [2:0] LAYOUT_LEFT     = 3'd2;
  localparam logic [2:0] LAYOUT_RIGHT    = 3'd3;
  localparam logic [2:0] LAYOUT_WIDE     = 3'd4;
  localparam logic [2:0] LAYOUT_QUAD     = 3'd5;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic        right_turn;
    logic        left_turn;
    logic        reverse_on;
    logic [11:0] speed_tenths;
  } item_t;

  typedef struct packed {
    logic [2:0] layout;
    logic       window_shown;
    logic       close_allowed;
    logic       speed_active;
    logic       request_ignored;
  } result_t;

  typedef struct packed {
    logic        video_enabled;
    logic        left_preferred;
    logic [11:0] speed_enter;
    logic [11:0] speed_exit;
    logic [15:0] release_delay;
  } cfg_t;

  function automatic logic [1:0] raw_view(input logic rev, input logic lft,
                                          input logic rgt, input logic [1:0] last);
    logic [1:0] v;
    if (rev) v = VIEW_REV;
    else if (lft && rgt) v = (last == TURN_LEFT) ? VIEW_LEFT : VIEW_RIGHT;
    else if (rgt) v = VIEW_RIGHT;
    else if (lft) v = VIEW_LEFT;
    else v = VIEW_NONE;
    return v;
  endfunction

endpackage

FILE: sv/cvms_regs.sv
// APB-style configuration registers of the camera view mode selector.
// Depends on cvms_pkg for register indexes and the cfg_t struct.
module cvms_regs import cvms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign pready = 1'b1;
  assign index  = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.video_enabled  <= 1'b1;
      cfg.left_preferred <= 1'b0;
      cfg.speed_enter    <= 12'd350;
      cfg.speed_exit     <= 12'd250;
      cfg.release_delay  <= 16'd3000;
    end else if (wr_en) begin
      unique case (index)
        REG_VIDEO_EN:  cfg.video_enabled  <= pwdata[0];
        REG_LEFT_PREF: cfg.left_preferred <= pwdata[0];
        REG_SPD_ENTER: cfg.speed_enter    <= pwdata[11:0];
        REG_SPD_EXIT:  cfg.speed_exit     <= pwdata[11:0];
        REG_REL_DELAY: cfg.release_delay  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_VIDEO_EN:  prdata[0]     = cfg.video_enabled;
      REG_LEFT_PREF: prdata[0]     = cfg.left_preferred;
      REG_SPD_ENTER: prdata[11:0]  = cfg.speed_enter;
      REG_SPD_EXIT:  prdata[11:0]  = cfg.speed_exit;
      REG_REL_DELAY: prdata[15:0]  = cfg.release_delay;
      default:       prdata        = '0;
    endcase
  end

endmodule

FILE: sv/cvms_core.sv
// View selection state and its single-pass next-state logic.
// Depends on cvms_pkg; state advances on each accepted word.
module cvms_core import cvms_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result_next
);

  typedef struct packed {
    logic        speed_mode;
    logic        reverse_level;
    logic        left_level;
    logic        right_level;
    logic [1:0]  last_turn;
    logic [1:0]  active_view;
    logic        user_opened;
    logic        frame_seen;
    logic [15:0] frame_age;
    logic        hold_running;
    logic [15:0] hold_elapsed;
  } state_t;

  state_t st, st_next;

  always_ff @(posedge clk) begin
    if (rst) st <= '0;
    else if (take) st <= st_next;
  end

  always_comb begin
    state_t     n;
    logic [1:0] raw;
    logic       fresh;
    logic       ignored;
    n = st;
    ignored = 1'b0;
    if (item.func <= FUNC_SET_RIGHT) begin
      n.frame_age  = '0;
      n.frame_seen = 1'b1;
    end
    case (item.func)
      FUNC_SYNC: begin
        if (item.left_turn && !st.left_level) n.last_turn = TURN_LEFT;
        if (item.right_turn && !st.right_level) n.last_turn = TURN_RIGHT;
        n.reverse_level = item.reverse_on;
        n.left_level    = item.left_turn;
        n.right_level   = item.right_turn;
      end
      FUNC_SET_REV: n.reverse_level = item.reverse_on;
      FUNC_SET_LEFT: begin
        if (item.left_turn) begin
          n.right_level = 1'b0;
          n.last_turn   = TURN_LEFT;
        end else if (st.last_turn == TURN_LEFT) begin
          n.last_turn = st.right_level ? TURN_RIGHT : TURN_NONE;
        end
        n.left_level = item.left_turn;
      end
      FUNC_SET_RIGHT: begin
        if (item.right_turn) begin
          n.left_level = 1'b0;
          n.last_turn  = TURN_RIGHT;
        end else if (st.last_turn == TURN_RIGHT) begin
          n.last_turn = st.left_level ? TURN_LEFT : TURN_NONE;
        end
        n.right_level = item.right_turn;
      end
      FUNC_SPEED: begin
        if (cfg.video_enabled && item.speed_tenths >= cfg.speed_enter) n.speed_mode = 1'b1;
        else if (!cfg.video_enabled || item.speed_tenths < cfg.speed_exit)
          n.speed_mode = 1'b0;
      end
      FUNC_TICK: begin
        if (st.frame_age != CNT_MAX) n.frame_age = st.frame_age + 16'd1;
        if (st.hold_running && st.hold_elapsed != CNT_MAX)
          n.hold_elapsed = st.hold_elapsed + 16'd1;
      end
      FUNC_OPEN: n.user_opened = 1'b1;
      default: begin
        if (st.active_view == VIEW_NONE && !st.hold_running) n.user_opened = 1'b0;
        else ignored = 1'b1;
      end
    endcase

    raw   = raw_view(n.reverse_level, n.left_level, n.right_level, n.last_turn);
    fresh = n.frame_seen && (n.frame_age < cfg.release_delay);

    if (item.func <= FUNC_SET_RIGHT) begin
      // signal change
      if (raw != VIEW_NONE) begin
        n.hold_running = 1'b0;
        n.hold_elapsed = '0;
        n.active_view  = raw;
      end else if (n.active_view != VIEW_NONE) begin
        if (!n.hold_running) begin
          n.hold_running = 1'b1;
          n.hold_elapsed = '0;
        end
      end else begin
        n.hold_running = 1'b0;
        n.hold_elapsed = '0;
      end
    end else if (item.func == FUNC_SPEED || item.func == FUNC_TICK) begin
      // release check
      if (n.active_view == VIEW_NONE || (fresh && raw != VIEW_NONE)) begin
        n.hold_running = 1'b0;
        n.hold_elapsed = '0;
      end else if (!n.hold_running) begin
        n.hold_running = 1'b1;
        n.hold_elapsed = (n.frame_seen && !fresh) ? n.frame_age : 16'd0;
      end else if (n.hold_elapsed >= cfg.release_delay) begin
        n.active_view   = VIEW_NONE;
        n.last_turn     = TURN_NONE;
        n.hold_running  = 1'b0;
        n.hold_elapsed  = '0;
        n.reverse_level = 1'b0;
        n.left_level    = 1'b0;
        n.right_level   = 1'b0;
      end
    end

    st_next = n;

    if (n.active_view != VIEW_NONE) result_next.layout = {1'b0, n.active_view};
    else if (n.speed_mode) result_next.layout = cfg.left_preferred ? LAYOUT_WIDE : LAYOUT_QUAD;
    else result_next.layout = LAYOUT_SURROUND;
    result_next.window_shown    = (n.active_view != VIEW_NONE) || n.user_opened;
    result_next.close_allowed   = (n.active_view == VIEW_NONE) && !n.hold_running;
    result_next.speed_active    = n.speed_mode;
    result_next.request_ignored = ignored;
  end

endmodule

FILE: sv/camera_view_mode_selector.sv
// Camera view mode selector, top level.
// Uses cvms_pkg, cvms_regs, cvms_core and camera_view_mode_selector_assert.svh.
//
// Input channel item/item_valid/item_stall carries one event word: a signal
// frame (sync, reverse, left, right), a speed sample, a 1 ms tick, or a user
// open or close request. Every accepted word gives exactly one result word on
// result/result_valid/result_stall, in the cycle after it is taken, in order.
// Throughput is one word per cycle: the whole state update is a single pass
// of flag and counter logic from the state registers into the result register.
// The result register is the only buffer. While it holds a result that the
// receiver stalls, item_stall is high and no new word is taken; the held
// result stays unchanged until taken.
// Reset (rst, synchronous) clears all view state and counters, empties the
// result register and loads the configuration registers with their defaults.
// Configuration is written through the APB-style port (one register per 32-bit
// word at byte address 4*index); the user keeps the block idle, which is not enforced.
module camera_view_mode_selector import cvms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  logic              item_valid,
  output logic              item_stall,
  output result_t           result,
  output logic              result_valid,
  input  logic              result_stall,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  result_t result_next;
  logic    take;
  logic    view_layout;
  logic    ignored_while_open;

  assign item_stall = result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  assign view_layout = (result.layout == LAYOUT_REV) || (result.layout == LAYOUT_LEFT) ||
                       (result.layout == LAYOUT_RIGHT);
  assign ignored_while_open = result.request_ignored && result.close_allowed;

  cvms_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cvms_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (item),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (take) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) result <= result_next;
  end

`include "camera_view_mode_selector_assert.svh"

  `CVMS_ASSERT_ALWAYS(a_rst_empty, rst |=> !result_valid, "result valid after reset")
  `CVMS_ASSERT(a_take_gives_result, take |=> result_valid, "accepted word gave no result")
  `CVMS_ASSERT(a_ignore_vs_close, result_valid |-> !ignored_while_open, "close refused while allowed")
  `CVMS_ASSERT(a_view_shown, (result_valid && view_layout) |-> result.window_shown, "view hidden")

endmodule

FILE: dv/tb_camera_view_mode_selector.sv
// Testbench for camera_view_mode_selector: directed and random event words,
// checked word by word against a predictor of the view selection state.
// Depends on cvms_pkg and the camera_view_mode_selector RTL.
module tb_camera_view_mode_selector;
  import cvms_pkg::*;

  class view_scoreboard;
    cfg_t      regs;
    bit        speed_mode, rev_lvl, left_lvl, right_lvl;
    bit        user_opened, frame_seen, hold_running;
    bit [1:0]  last_turn, active_view;
    bit [15:0] frame_age, hold_elapsed;
    result_t   expected_views[$];
    int        errors;

    function new();
      regs = '{video_enabled: 1'b1, left_preferred: 1'b0, speed_enter: 12'd350,
               speed_exit: 12'd250, release_delay: 16'd3000};
      speed_mode = 0; rev_lvl = 0; left_lvl = 0; right_lvl = 0;
      user_opened = 0; frame_seen = 0; hold_running = 0;
      last_turn = TURN_NONE; active_view = VIEW_NONE;
      frame_age = 0; hold_elapsed = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_VIDEO_EN:  regs.video_enabled = val[0];
        REG_LEFT_PREF: regs.left_preferred = val[0];
        REG_SPD_ENTER: regs.speed_enter = val[11:0];
        REG_SPD_EXIT:  regs.speed_exit = val[11:0];
        REG_REL_DELAY: regs.release_delay = val[15:0];
        default: ;
      endcase
    endfunction

    function bit [1:0] wanted_view();
      if (rev_lvl) return VIEW_REV;
      if (left_lvl && right_lvl) return (last_turn == TURN_LEFT) ? VIEW_LEFT : VIEW_RIGHT;
      if (right_lvl) return VIEW_RIGHT;
      if (left_lvl) return VIEW_LEFT;
      return VIEW_NONE;
    endfunction

    function void drop_view();
      active_view = VIEW_NONE;
      last_turn = TURN_NONE;
      hold_running = 0;
      hold_elapsed = 0;
      rev_lvl = 0;
      left_lvl = 0;
      right_lvl = 0;
    endfunction

    function void settle_signals();
      bit [1:0] v;
      v = wanted_view();
      if (v != VIEW_NONE) begin
        hold_running = 0;
        hold_elapsed = 0;
        active_view = v;
      end else if (active_view != VIEW_NONE) begin
        if (!hold_running) begin
          hold_running = 1;
          hold_elapsed = 0;
        end
      end else begin
        hold_running = 0;
        hold_elapsed = 0;
      end
    endfunction

    function void check_release();
      bit fresh;
      fresh = frame_seen && frame_age < regs.release_delay;
      if (active_view == VIEW_NONE || (fresh && wanted_view() != VIEW_NONE)) begin
        hold_running = 0;
        hold_elapsed = 0;
      end else if (!hold_running) begin
        // stale frames: the hold has already been running since the last frame
        hold_running = 1;
        hold_elapsed = (frame_seen && frame_age >= regs.release_delay) ? frame_age : 16'd0;
      end else if (hold_elapsed >= regs.release_delay) begin
        drop_view();
      end
    endfunction

    function void note_item(item_t w);
      result_t r;
      bit      ignored;
      ignored = 0;
      if (w.func inside {FUNC_SYNC, FUNC_SET_REV, FUNC_SET_LEFT, FUNC_SET_RIGHT}) begin
        frame_age = 0;
        frame_seen = 1;
      end
      case (w.func)
        FUNC_SYNC: begin
          if (w.left_turn && !left_lvl) last_turn = TURN_LEFT;
          if (w.right_turn && !right_lvl) last_turn = TURN_RIGHT;
          rev_lvl = w.reverse_on;
          left_lvl = w.left_turn;
          right_lvl = w.right_turn;
          settle_signals();
        end
        FUNC_SET_REV: begin
          rev_lvl = w.reverse_on;
          settle_signals();
        end
        FUNC_SET_LEFT: begin
          if (w.left_turn) begin
            right_lvl = 0;
            last_turn = TURN_LEFT;
          end else if (last_turn == TURN_LEFT) begin
            last_turn = right_lvl ? TURN_RIGHT : TURN_NONE;
          end
          left_lvl = w.left_turn;
          settle_signals();
        end
        FUNC_SET_RIGHT: begin
          if (w.right_turn) begin
            left_lvl = 0;
            last_turn = TURN_RIGHT;
          end else if (last_turn == TURN_RIGHT) begin
            last_turn = left_lvl ? TURN_LEFT : TURN_NONE;
          end
          right_lvl = w.right_turn;
          settle_signals();
        end
        FUNC_SPEED: begin
          if (regs.video_enabled && w.speed_tenths >= regs.speed_enter) speed_mode = 1;
          else if (!regs.video_enabled || w.speed_tenths < regs.speed_exit) speed_mode = 0;
          check_release();
        end
        FUNC_TICK: begin
          if (frame_age != CNT_MAX) frame_age++;
          if (hold_running && hold_elapsed != CNT_MAX) hold_elapsed++;
          check_release();
        end
        FUNC_OPEN: user_opened = 1;
        FUNC_CLOSE: begin
          if (active_view == VIEW_NONE && !hold_running) user_opened = 0;
          else ignored = 1;
        end
      endcase
      case (active_view)
        VIEW_REV:   r.layout = LAYOUT_REV;
        VIEW_LEFT:  r.layout = LAYOUT_LEFT;
        VIEW_RIGHT: r.layout = LAYOUT_RIGHT;
        default: begin
          if (!speed_mode) r.layout = LAYOUT_SURROUND;
          else r.layout = regs.left_preferred ? LAYOUT_WIDE : LAYOUT_QUAD;
        end
      endcase
      r.window_shown = (active_view != VIEW_NONE) || user_opened;
      r.close_allowed = (active_view == VIEW_NONE) && !hold_running;
      r.speed_active = speed_mode;
      r.request_ignored = ignored;
      expected_views.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_views.size() == 0) begin
        $display("%0t: result word %h with none expected", $time, got);
        errors++;
        return;
      end
      want = expected_views.pop_front();
      if (got.layout !== want.layout)
        $display("%0t: layout expected %0d actual %0d", $time, want.layout, got.layout);
      if (got.window_shown !== want.window_shown)
        $display("%0t: window_shown expected %0d actual %0d", $time,
                 want.window_shown, got.window_shown);
      if (got.close_allowed !== want.close_allowed)
        $display("%0t: close_allowed expected %0d actual %0d", $time,
                 want.close_allowed, got.close_allowed);
      if (got.speed_active !== want.speed_active)
        $display("%0t: speed_active expected %0d actual %0d", $time,
                 want.speed_active, got.speed_active);
      if (got.request_ignored !== want.request_ignored)
        $display("%0t: request_ignored expected %0d actual %0d", $time,
                 want.request_ignored, got.request_ignored);
      if (got !== want) errors++;
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  item_t             item = '0;
  logic              item_valid = 1'b0;
  logic              item_stall;
  result_t           result;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  view_scoreboard sb = new();
  bit             calm = 1'b0;
  int             stall_left = 0;
  int             words_sent = 0;

  camera_view_mode_selector dut (
    .clk(clk), .rst(rst),
    .item(item), .item_valid(item_valid), .item_stall(item_stall),
    .result(result), .result_valid(result_valid), .result_stall(result_stall),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic item_t any_word();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t word(logic [2:0] f, int rt, int lt, int rv, int spd);
    item_t w;
    w.func = f;
    w.right_turn = rt[0];
    w.left_turn = lt[0];
    w.reverse_on = rv[0];
    w.speed_tenths = spd[11:0];
    return w;
  endfunction

  function automatic logic [11:0] speed_near();
    int v;
    v = $urandom_range(0, 1) ? int'(sb.regs.speed_enter) : int'(sb.regs.speed_exit);
    v = v + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      stall_left <= idle_len();
    end
  end

  task automatic send_word(input item_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(w);
    words_sent++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.expected_views.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_regs(input cfg_t c);
    wait_idle();
    write_reg(REG_VIDEO_EN, 32'(c.video_enabled));
    write_reg(REG_LEFT_PREF, 32'(c.left_preferred));
    write_reg(REG_SPD_ENTER, 32'(c.speed_enter));
    write_reg(REG_SPD_EXIT, 32'(c.speed_exit));
    write_reg(REG_REL_DELAY, 32'(c.release_delay));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // signal episodes are followed by tick runs that can reach a release; speed words cluster at the thresholds
  task automatic run_phase(input int words);
    int    stop_at, len, dly;
    item_t w;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(1, 4)) begin
            w = any_word();
            w.func = 3'($urandom_range(FUNC_SYNC, FUNC_SET_RIGHT));
            send_word(w);
          end
          dly = sb.regs.release_delay;
          len = (dly <= 60) ? $urandom_range(0, 2 * dly + 4) : $urandom_range(0, 40);
          repeat (len) begin
            w = any_word();
            if ($urandom_range(0, 7) != 0) w.func = FUNC_TICK;
            send_word(w);
          end
        end
        5, 6: begin
          repeat ($urandom_range(2, 8)) begin
            w = any_word();
            w.func = FUNC_SPEED;
            if ($urandom_range(0, 3) != 0) w.speed_tenths = speed_near();
            send_word(w);
          end
        end
        7: begin
          repeat ($urandom_range(1, 3)) begin
            w = any_word();
            w.func = $urandom_range(0, 1) ? FUNC_OPEN : FUNC_CLOSE;
            send_word(w);
          end
        end
        default: repeat ($urandom_range(1, 5)) send_word(any_word());
      endcase
    end
  endtask

  initial begin
    cfg_t c;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: thresholds, reverse priority, turn ordering, close refusal
    send_word(word(FUNC_TICK, 0, 0, 0, 0));
    send_word(word(FUNC_SPEED, 0, 0, 0, 4095));
    send_word(word(FUNC_SPEED, 0, 0, 0, 300));
    send_word(word(FUNC_SPEED, 0, 0, 0, 249));
    send_word(word(FUNC_SPEED, 0, 0, 0, 350));
    send_word(word(FUNC_OPEN, 0, 0, 0, 0));
    send_word(word(FUNC_CLOSE, 0, 0, 0, 0));
    send_word(word(FUNC_SYNC, 1, 1, 1, 0));
    send_word(word(FUNC_SET_REV, 0, 0, 0, 0));
    send_word(word(FUNC_SET_LEFT, 0, 1, 0, 0));
    send_word(word(FUNC_SET_RIGHT, 1, 0, 0, 0));
    send_word(word(FUNC_CLOSE, 0, 0, 0, 0));
    send_word(word(FUNC_SET_RIGHT, 0, 0, 0, 0));
    send_word(word(FUNC_CLOSE, 1, 1, 1, 4095));

    // short hold, crossed thresholds, hold start on stale frames
    load_regs('{video_enabled: 1'b1, left_preferred: 1'b1, speed_enter: 12'd100,
                speed_exit: 12'd200, release_delay: 16'd2});
    repeat (3) send_word(word(FUNC_TICK, 0, 0, 0, 0));
    send_word(word(FUNC_SPEED, 0, 0, 0, 150));
    send_word(word(FUNC_SPEED, 0, 0, 0, 50));
    send_word(word(FUNC_SET_LEFT, 0, 1, 0, 0));
    repeat (3) send_word(word(FUNC_TICK, 0, 0, 0, 0));
    send_word(word(FUNC_SPEED, 0, 0, 0, 4095));

    // video off leaves speed mode until the next speed word; zero release delay
    load_regs('{video_enabled: 1'b0, left_preferred: 1'b0, speed_enter: 12'd4095,
                speed_exit: 12'd0, release_delay: 16'd0});
    send_word(word(FUNC_TICK, 0, 0, 0, 0));
    send_word(word(FUNC_SPEED, 0, 0, 0, 4095));
    send_word(word(FUNC_SET_REV, 0, 0, 1, 0));
    repeat (2) send_word(word(FUNC_TICK, 0, 0, 0, 0));
    send_word(word(FUNC_CLOSE, 0, 0, 0, 0));

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        c = '{video_enabled: 1'b0, left_preferred: 1'b0, speed_enter: 12'd0,
              speed_exit: 12'd0, release_delay: 16'd1};
      end else if (p == 1) begin
        c = '{video_enabled: 1'b1, left_preferred: 1'b1, speed_enter: 12'd4095,
              speed_exit: 12'd4095, release_delay: 16'hFFFF};
      end else begin
        c.video_enabled = 1'($urandom);
        c.left_preferred = 1'($urandom);
        c.speed_enter = 12'($urandom);
        c.speed_exit = 12'($urandom);
        c.release_delay = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                                      : 16'($urandom_range(1, 40));
      end
      load_regs(c);
      calm = ($urandom_range(0, 3) == 0);
      run_phase(105);
    end
    calm = 1'b0;

    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_views.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: camera_view_mode_selector.f
+incdir+sv
sv/cvms_pkg.sv
sv/cvms_regs.sv
sv/cvms_core.sv
sv/camera_view_mode_selector.sv
dv/tb_camera_view_mode_selector.sv
